>>> hw/rtl/tsc_pkg.sv
package tsc_pkg;

    // Q3.F format: sign plus three integer bits above the fraction
    localparam int unsigned INT_BITS  = 4;
    // integer headroom above the fraction for term magnitudes (max about 416)
    localparam int unsigned TERM_HEAD = 10;
    // headroom for term * |x| + n/2 ahead of the divide by n
    localparam int unsigned PROD_HEAD = 13;
    // signed accumulator headroom (series sums stay below 2^12)
    localparam int unsigned ACC_HEAD  = 14;

    // Sign of the term of power pow in its series.
    // x^n/n! is negative for negative x and odd n; the series flips
    // powers with n mod 4 of 2 or 3.
    function automatic logic term_subtract(input int unsigned pow, input logic xneg);
        logic       neg;
        logic [1:0] phase;
        phase = pow[1:0];
        neg   = xneg & pow[0];
        if (phase == 2'd2 || phase == 2'd3) begin
            neg = ~neg;
        end
        return neg;
    endfunction

endpackage

>>> hw/rtl/tsc_mul.sv
// Two-stage unsigned multiply: four partial products, then sum plus addend.
module tsc_mul #(
    parameter int unsigned A_WIDTH = 32,
    parameter int unsigned B_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [A_WIDTH-1:0]         a,
    input  logic [B_WIDTH-1:0]         b,
    input  logic [A_WIDTH+B_WIDTH-1:0] addend,
    output logic [A_WIDTH+B_WIDTH-1:0] product
);

    localparam int unsigned ALO = A_WIDTH / 2;
    localparam int unsigned AHI = A_WIDTH - ALO;
    localparam int unsigned BLO = B_WIDTH / 2;
    localparam int unsigned BHI = B_WIDTH - BLO;
    localparam int unsigned PW  = A_WIDTH + B_WIDTH;

    logic [ALO+BLO-1:0] pp_ll_reg;
    logic [ALO+BHI-1:0] pp_lh_reg;
    logic [AHI+BLO-1:0] pp_hl_reg;
    logic [AHI+BHI-1:0] pp_hh_reg;
    logic [PW-1:0]      product_reg;
    logic [PW-1:0]      product_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= a[ALO-1:0]       * b[BLO-1:0];
            pp_lh_reg <= a[ALO-1:0]       * b[B_WIDTH-1:BLO];
            pp_hl_reg <= a[A_WIDTH-1:ALO] * b[BLO-1:0];
            pp_hh_reg <= a[A_WIDTH-1:ALO] * b[B_WIDTH-1:BLO];
        end
    end

    always_comb begin
        product_next = PW'(pp_ll_reg)
                     + (PW'(pp_lh_reg) << BLO)
                     + (PW'(pp_hl_reg) << ALO)
                     + (PW'(pp_hh_reg) << (ALO + BLO))
                     + addend;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

>>> hw/rtl/tsc_term.sv
// One series term: t(n) = round(round(t(n-1) * |x|) / n), added to or subtracted from sine or cosine.
// Four stages: two for the multiply by |x|, two for the reciprocal multiply by 1/n.
module tsc_term #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned POW        = 1
) (
    input  logic                                                          aclk,
    input  logic                                                          aresetn,
    input  logic                                                          en,
    input  logic                                                          valid_in,
    input  logic                                                          xneg_in,
    input  logic [DATA_WIDTH-1:0]                                         xmag_in,
    input  logic [DATA_WIDTH-tsc_pkg::INT_BITS+tsc_pkg::TERM_HEAD-1:0]    term_in,
    input  logic signed [DATA_WIDTH-tsc_pkg::INT_BITS+tsc_pkg::ACC_HEAD-1:0] sin_in,
    input  logic signed [DATA_WIDTH-tsc_pkg::INT_BITS+tsc_pkg::ACC_HEAD-1:0] cos_in,
    output logic                                                          valid_out,
    output logic                                                          xneg_out,
    output logic [DATA_WIDTH-1:0]                                         xmag_out,
    output logic [DATA_WIDTH-tsc_pkg::INT_BITS+tsc_pkg::TERM_HEAD-1:0]    term_out,
    output logic signed [DATA_WIDTH-tsc_pkg::INT_BITS+tsc_pkg::ACC_HEAD-1:0] sin_out,
    output logic signed [DATA_WIDTH-tsc_pkg::INT_BITS+tsc_pkg::ACC_HEAD-1:0] cos_out
);

    localparam int unsigned F     = DATA_WIDTH - tsc_pkg::INT_BITS;
    localparam int unsigned TW    = F + tsc_pkg::TERM_HEAD;
    localparam int unsigned PW    = F + tsc_pkg::PROD_HEAD;
    localparam int unsigned AW    = F + tsc_pkg::ACC_HEAD;
    localparam int unsigned MW    = PW + 1;
    localparam int unsigned L     = $clog2(POW);
    localparam int unsigned P1W   = TW + DATA_WIDTH;
    localparam int unsigned P2W   = PW + MW;
    localparam int unsigned DEPTH = 4;
    localparam logic        ODD   = (POW % 2) == 1;

    // exact floor(a/n) for a < 2^PW: ceil(2^(PW+L)/n), then shift by PW+L
    localparam logic [MW-1:0]  RECIP = MW'(((128'(1) << (PW + L)) + 128'(POW) - 128'(1))
                                           / 128'(POW));
    // rounding half of the Q shift, plus floor(n/2) ahead of the divide
    localparam logic [P1W-1:0] RND1  = P1W'((128'(1) << (F - 1)) + (128'(POW / 2) << F));

    logic                 valid_reg [DEPTH];
    logic                 xneg_reg  [DEPTH];
    logic [DATA_WIDTH-1:0] xmag_reg [DEPTH];
    logic signed [AW-1:0] sin_reg   [DEPTH];
    logic signed [AW-1:0] cos_reg   [DEPTH];

    logic [P1W-1:0]       p1;
    logic [PW-1:0]        dividend;
    logic [P2W-1:0]       p2;
    logic [TW-1:0]        quot;
    logic signed [AW-1:0] quot_ext;
    logic signed [AW-1:0] acc_src;
    logic signed [AW-1:0] acc_new;
    logic                 neg;

    tsc_mul #(
        .A_WIDTH(TW),
        .B_WIDTH(DATA_WIDTH)
    ) u_mul_x (
        .aclk   (aclk),
        .en     (en),
        .a      (term_in),
        .b      (xmag_in),
        .addend (RND1),
        .product(p1)
    );

    assign dividend = PW'(p1 >> F);

    tsc_mul #(
        .A_WIDTH(PW),
        .B_WIDTH(MW)
    ) u_mul_recip (
        .aclk   (aclk),
        .en     (en),
        .a      (dividend),
        .b      (RECIP),
        .addend ('0),
        .product(p2)
    );

    assign quot = TW'(p2 >> (PW + L));

    // side data rides along with the multiplies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= valid_in;
            for (int i = 1; i < DEPTH; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xneg_reg[0] <= xneg_in;
            xmag_reg[0] <= xmag_in;
            sin_reg[0]  <= sin_in;
            cos_reg[0]  <= cos_in;
            for (int i = 1; i < DEPTH; i++) begin
                xneg_reg[i] <= xneg_reg[i-1];
                xmag_reg[i] <= xmag_reg[i-1];
                sin_reg[i]  <= sin_reg[i-1];
                cos_reg[i]  <= cos_reg[i-1];
            end
        end
    end

    always_comb begin
        quot_ext = AW'(quot);
        neg      = tsc_pkg::term_subtract(POW, xneg_reg[DEPTH-1]);
        acc_src  = ODD ? sin_reg[DEPTH-1] : cos_reg[DEPTH-1];
        acc_new  = neg ? (acc_src - quot_ext) : (acc_src + quot_ext);
    end

    assign valid_out = valid_reg[DEPTH-1];
    assign xneg_out  = xneg_reg[DEPTH-1];
    assign xmag_out  = xmag_reg[DEPTH-1];
    assign term_out  = quot;
    assign sin_out   = ODD ? acc_new : sin_reg[DEPTH-1];
    assign cos_out   = ODD ? cos_reg[DEPTH-1] : acc_new;

endmodule

>>> hw/rtl/sine_cosine_taylor_series.sv
// Sine and cosine of a signed Q3.F angle (F = DATA_WIDTH-4, Q3.28 by default) by a
// Taylor series truncated at power TERM_POWER_MAX. Each term is built from the one
// before as t(n) = t(n-1)*|x|/n with round-half-up on the magnitude, then added to or
// subtracted from the sine (odd n) or cosine (even n) sum; both sums saturate to the
// signed DATA_WIDTH range. Fully pipelined: one word per cycle in and out while m_tready
// stays high, no state kept between words. The pipeline is an input register, four
// stages per term (two for the multiply by |x|, two for the reciprocal multiply that
// divides by n) and the output register. Angles far outside about -pi..pi are still
// evaluated, and their sums can clamp. A stalled output holds the pipeline only when a
// finished word is waiting behind it.
module sine_cosine_taylor_series #(
    parameter int unsigned TERM_POWER_MAX = 15,
    parameter int unsigned DATA_WIDTH     = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input word
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]        s_tdata,   // angle
    // result word
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_tdata    // sine, cosine
);

    localparam int unsigned F      = DATA_WIDTH - tsc_pkg::INT_BITS;
    localparam int unsigned TW     = F + tsc_pkg::TERM_HEAD;
    localparam int unsigned AW     = F + tsc_pkg::ACC_HEAD;
    localparam int unsigned OUT_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;

    localparam logic [TW-1:0]        ONE     = TW'(128'(1) << F);
    localparam logic signed [AW-1:0] SAT_MAX = AW'((128'(1) << (DATA_WIDTH - 1)) - 128'(1));
    localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;

    // pipeline advances unless a finished word is both waiting at the output
    // and about to be followed by another one
    logic en;

    // input register
    logic                  in_valid_reg;
    logic                  xneg_reg;
    logic [DATA_WIDTH-1:0] xmag_reg;
    logic [DATA_WIDTH-1:0] angle;

    // term chain, index k holds the values after term k
    logic                  valid_c [TERM_POWER_MAX+1];
    logic                  xneg_c  [TERM_POWER_MAX+1];
    logic [DATA_WIDTH-1:0] xmag_c  [TERM_POWER_MAX+1];
    logic [TW-1:0]         term_c  [TERM_POWER_MAX+1];
    logic signed [AW-1:0]  sin_c   [TERM_POWER_MAX+1];
    logic signed [AW-1:0]  cos_c   [TERM_POWER_MAX+1];

    // output register
    logic                  m_tvalid_reg;
    logic [DATA_WIDTH-1:0] sine_reg;
    logic [DATA_WIDTH-1:0] cosine_reg;
    logic [DATA_WIDTH-1:0] sine_next;
    logic [DATA_WIDTH-1:0] cosine_next;

    logic                  last_valid;

    assign last_valid = valid_c[TERM_POWER_MAX];
    assign en         = !m_tvalid_reg || m_tready || !last_valid;
    assign s_tready   = en;
    assign angle      = s_tdata[DATA_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // sign and magnitude; the most negative angle keeps magnitude 2^(W-1)
    always_ff @(posedge aclk) begin
        if (en) begin
            xneg_reg <= angle[DATA_WIDTH-1];
            xmag_reg <= angle[DATA_WIDTH-1] ? (~angle + 1'b1) : angle;
        end
    end

    // series seed: term 1.0, sine 0, cosine 1.0
    assign valid_c[0] = in_valid_reg;
    assign xneg_c[0]  = xneg_reg;
    assign xmag_c[0]  = xmag_reg;
    assign term_c[0]  = ONE;
    assign sin_c[0]   = '0;
    assign cos_c[0]   = AW'(ONE);

    for (genvar k = 1; k <= TERM_POWER_MAX; k++) begin : g_term
        tsc_term #(
            .DATA_WIDTH(DATA_WIDTH),
            .POW       (k)
        ) u_term (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .valid_in (valid_c[k-1]),
            .xneg_in  (xneg_c[k-1]),
            .xmag_in  (xmag_c[k-1]),
            .term_in  (term_c[k-1]),
            .sin_in   (sin_c[k-1]),
            .cos_in   (cos_c[k-1]),
            .valid_out(valid_c[k]),
            .xneg_out (xneg_c[k]),
            .xmag_out (xmag_c[k]),
            .term_out (term_c[k]),
            .sin_out  (sin_c[k]),
            .cos_out  (cos_c[k])
        );
    end

    // clamp both sums to the signed output range
    always_comb begin
        if (sin_c[TERM_POWER_MAX] > SAT_MAX) begin
            sine_next = DATA_WIDTH'(SAT_MAX);
        end else if (sin_c[TERM_POWER_MAX] < SAT_MIN) begin
            sine_next = DATA_WIDTH'(SAT_MIN);
        end else begin
            sine_next = DATA_WIDTH'(sin_c[TERM_POWER_MAX]);
        end
        if (cos_c[TERM_POWER_MAX] > SAT_MAX) begin
            cosine_next = DATA_WIDTH'(SAT_MAX);
        end else if (cos_c[TERM_POWER_MAX] < SAT_MIN) begin
            cosine_next = DATA_WIDTH'(SAT_MIN);
        end else begin
            cosine_next = DATA_WIDTH'(cos_c[TERM_POWER_MAX]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && last_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && last_valid) begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({cosine_reg, sine_reg});

endmodule

>>> tb/sine_cosine_taylor_series_test.sv
`timescale 1ns / 1ps

module sine_cosine_taylor_series_test;

    // Default build: Q3.28 words, series through x^15
    localparam int unsigned DW      = 32;
    localparam int unsigned POW_MAX = 15;
    localparam int unsigned FRAC    = DW - 4;

    // Pipeline depth is 4*POW_MAX + 2; drain a little past that at the end
    localparam int unsigned DRAIN_CYCLES = 4 * POW_MAX + 10;

    localparam int unsigned RANDOM_WORDS = 1930;
    localparam int unsigned CALM_TAIL    = 300;    // last words, no idling on either side
    localparam int unsigned FLUSH_AT     = 700;    // sender holds off until all results are in

    // pi and related angles in Q3.28
    localparam logic [DW-1:0] Q_PI      = 32'h3243_F6A9;
    localparam logic [DW-1:0] Q_HALF_PI = 32'h1921_FB54;
    localparam logic [DW-1:0] Q_ONE     = 32'h1000_0000;

    // Result word: sine in the low half, cosine in the high half (matches m_tdata)
    typedef struct packed {
        logic [DW-1:0] cosine;
        logic [DW-1:0] sine;
    } sincos_t;

    // One directed row; sine/cosine are only used where 'typed' is set
    typedef struct packed {
        logic [DW-1:0] angle;
        logic          typed;
        logic [DW-1:0] sine;
        logic [DW-1:0] cosine;
    } angle_row_t;

    localparam int unsigned DIRECTED_ROWS = 21;

    angle_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // zero angle: sin 0, cos exactly 1.0
        '{32'h0000_0000, 1'b1, 32'h0000_0000, Q_ONE},
        // one LSB either side: only the linear term survives rounding
        '{32'h0000_0001, 1'b1, 32'h0000_0001, Q_ONE},
        '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, Q_ONE},
        // extremes of the angle field, far past pi: the cosine sum clamps
        '{32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0, 32'h0},   // most negative, magnitude used as is
        '{Q_ONE,         1'b0, 32'h0, 32'h0},
        '{32'hF000_0000, 1'b0, 32'h0, 32'h0},
        '{Q_HALF_PI,     1'b0, 32'h0, 32'h0},
        '{32'hE6DE_04AC, 1'b0, 32'h0, 32'h0},   // -pi/2
        '{Q_PI,          1'b0, 32'h0, 32'h0},
        '{32'hCDBC_0957, 1'b0, 32'h0, 32'h0},   // -pi
        '{32'h0C90_FDAA, 1'b0, 32'h0, 32'h0},   // pi/4
        '{32'h2000_0000, 1'b0, 32'h0, 32'h0},   // 2.0
        '{32'h4000_0000, 1'b0, 32'h0, 32'h0},   // 4.0
        '{32'hC000_0000, 1'b0, 32'h0, 32'h0},   // -4.0
        '{32'h6487_ED51, 1'b0, 32'h0, 32'h0},   // 2*pi
        '{32'h9B78_12AF, 1'b0, 32'h0, 32'h0},   // -2*pi
        '{32'h5555_5555, 1'b0, 32'h0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0, 32'h0},
        '{32'h0000_0100, 1'b0, 32'h0, 32'h0},
        '{32'hFFFF_FF00, 1'b0, 32'h0, 32'h0}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [DW-1:0]       s_tdata;    // angle
    logic                m_tvalid;
    logic                m_tready;
    logic [2*DW-1:0]     m_tdata;    // sine, cosine

    // Expected result riding alongside the word on the input bus
    logic                row_typed;
    sincos_t             row_want;

    sincos_t             pending_sincos [$];
    sincos_t             got_word;
    sincos_t             want_word;
    int unsigned         mismatch_count;
    bit                  idle_on;

    sine_cosine_taylor_series #(
        .TERM_POWER_MAX (POW_MAX),
        .DATA_WIDTH     (DW)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Clamp a series sum to the signed word range
    function automatic logic [DW-1:0] clamp_word(input longint sum);
        longint hi;
        longint lo;
        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        if (sum > hi) begin
            sum = hi;
        end else if (sum < lo) begin
            sum = lo;
        end
        return sum[DW-1:0];
    endfunction

    // Series evaluation: magnitude terms t(n) = round(round(t(n-1)*|x|) / n),
    // sign from x^n/n! and from the alternation of each series.
    function automatic sincos_t taylor_sincos(input logic [DW-1:0] angle);
        logic           xneg;
        logic [DW:0]    xmag;
        logic [63:0]    term;
        logic [127:0]   prod;
        logic           minus;
        longint         sin_sum;
        longint         cos_sum;
        int             n;
        sincos_t        res;
        xneg = angle[DW-1];
        xmag = xneg ? (({1'b1, {DW{1'b0}}}) - {1'b0, angle}) : {1'b0, angle};
        term = 64'd1 << FRAC;
        sin_sum = 0;
        cos_sum = longint'(term);
        for (n = 1; n <= POW_MAX; n++) begin
            prod = 128'(term) * 128'(xmag) + (128'd1 << (FRAC - 1));
            prod = (prod >> FRAC) + 128'(n / 2);
            term = 64'(prod / 128'(n));
            // odd power of a negative angle is negative; powers 2,3 mod 4 flip
            minus = xneg & n[0];
            if (n[1]) begin
                minus = ~minus;
            end
            if (n[0]) begin
                sin_sum = minus ? sin_sum - longint'(term) : sin_sum + longint'(term);
            end else begin
                cos_sum = minus ? cos_sum - longint'(term) : cos_sum + longint'(term);
            end
        end
        res.sine   = clamp_word(sin_sum);
        res.cosine = clamp_word(cos_sum);
        return res;
    endfunction

    task automatic report_fault(input string what);
        if (mismatch_count < 10) begin
            $display("%0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // Present one angle at the falling edge and hold it until accepted.
    // With idling on, the bus sometimes goes quiet first.
    task automatic send_angle(input logic [DW-1:0] angle, input logic typed,
                              input sincos_t want);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid  <= 1'b1;
        s_tdata   <= angle;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Scoreboard: check leaving words first, then log the word just taken in
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_word = m_tdata;
                if (pending_sincos.size() == 0) begin
                    report_fault($sformatf("unexpected result sine %h cosine %h",
                                           got_word.sine, got_word.cosine));
                end else begin
                    want_word = pending_sincos.pop_front();
                    if (got_word.sine !== want_word.sine) begin
                        report_fault($sformatf("sine: expected %h, got %h",
                                               want_word.sine, got_word.sine));
                    end
                    if (got_word.cosine !== want_word.cosine) begin
                        report_fault($sformatf("cosine: expected %h, got %h",
                                               want_word.cosine, got_word.cosine));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_sincos.push_back(row_typed ? row_want : taylor_sincos(s_tdata));
            end
        end
    end

    // Result side: random stalls while idling is on
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("sine_cosine_taylor_series_test failed");
        $finish;
    end

    initial begin
        logic [DW-1:0] angle;
        int unsigned   pick;
        int unsigned   i;
        sincos_t       none;
        none           = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        row_typed      = 1'b0;
        row_want       = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows: field extremes, tiny angles, multiples of pi, clamping
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            send_angle(directed_rows[i].angle, directed_rows[i].typed,
                       '{cosine: directed_rows[i].cosine, sine: directed_rows[i].sine});
        end

        // Random part: mostly in-range angles, some full-range, some near zero
        for (i = 0; i < RANDOM_WORDS; i++) begin
            // quiet stretches every fourth block of 200 and over the tail
            idle_on = (i < RANDOM_WORDS - CALM_TAIL) && ((i / 200) % 4 != 3);
            if (i == FLUSH_AT) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_sincos.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                angle = $urandom_range(0, 2 * Q_PI) - Q_PI;
            end else if (pick < 85) begin
                angle = $urandom;
            end else begin
                angle = $urandom_range(0, 2047) - 1024;
            end
            send_angle(angle, 1'b0, none);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_sincos.size() != 0) @(posedge aclk);
        // anything still in the pipe would show up as an unexpected result
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_sincos.size() == 0) begin
            $display("sine_cosine_taylor_series_test passed");
        end else begin
            $display("sine_cosine_taylor_series_test failed");
        end
        $finish;
    end

endmodule
